@@ hw/rtl/mfuf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback package
// Shared constants and types for the unwrap and filter block.
// ----------------------------------------------------------------------------
package mfuf_pkg;

    localparam int EncoderCountsDefault = 8192;
    localparam int MotorCountDefault    = 4;

    localparam logic [10:0] ID_BASE        = 11'h201;
    localparam int          JumpLimit      = 4000;
    localparam int          UnwrapMargin   = 10;
    localparam int          SpeedDeadband  = 5;
    localparam logic [31:0] VARIANCE_RESET = 32'd25600;

    localparam logic [1:0] REG_DECIMATION = 2'd0;
    localparam logic [1:0] REG_PROCESS    = 2'd1;
    localparam logic [1:0] REG_MEASURE    = 2'd2;

    typedef struct packed {
        logic        start;
        logic [33:0] vp;
        logic [34:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quot;
    } div_rsp_t;

endpackage

@@ hw/rtl/motor_feedback_unwrap_filter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback unwrap and filter unit
// Per-motor speed filtering and encoder delta unwrapping for CAN feedback.
// ----------------------------------------------------------------------------
// A motor frame runs through the filter steps, each of which waits on the
// bit-serial gain divider that both filter steps share: the speed step and,
// on an angle update frame, the delta step after it. Frames for other
// identifiers are taken and give no result. A result waits in an output
// register while the next frame is already being worked on; the block takes
// no new frame while it works on one, and holds a finished result back until
// the previous one has been taken.
module motor_feedback_unwrap_filter_unit
    import mfuf_pkg::*;
#(
    parameter int ENCODER_COUNTS = EncoderCountsDefault,
    parameter int MOTOR_COUNT    = MotorCountDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // frame_id[10:0], angle_word[23:11], speed_word[39:24]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // motor_index[1:0], speed_filtered[17:2], delta_filtered[33:18]
    output logic [39:0] m_tdata,
    // angle_updated
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int SW = $clog2(2 * MOTOR_COUNT);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_PRED  = 10'b0000000010,
        ST_DIV   = 10'b0000000100,
        ST_MUL   = 10'b0000001000,
        ST_EST   = 10'b0000010000,
        ST_VAR   = 10'b0000100000,
        ST_POST  = 10'b0001000000,
        ST_UNWRP = 10'b0010000000,
        ST_JUMP  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  decim_reg;
    logic [15:0] pnoise_reg, mnoise_reg;

    logic [7:0]         cnt_reg     [MOTOR_COUNT];
    logic [12:0]        prev_reg    [MOTOR_COUNT];
    logic signed [15:0] good_reg    [MOTOR_COUNT];
    logic signed [31:0] est_reg     [2*MOTOR_COUNT];
    logic [31:0]        var_reg     [2*MOTOR_COUNT];

    logic [MW-1:0]      m_reg;
    logic [12:0]        angle_reg;
    logic signed [16:0] x_reg;
    logic               upd_reg, phase_reg;
    logic [SW-1:0]      slot_reg;
    logic [33:0]        vp_reg;
    logic [16:0]        k_reg;
    logic signed [41:0] diff_reg;
    logic signed [59:0] prod_reg;
    logic signed [15:0] fs_reg, fd_reg;
    logic signed [17:0] d_reg;

    logic        out_valid_reg;
    logic [1:0]  out_m_reg;
    logic [15:0] out_fs_reg, out_fd_reg;
    logic        out_upd_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    mfuf_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic [10:0] in_id;
    logic        in_hit;
    logic [10:0] in_off;
    assign in_id  = s_tdata[10:0];
    assign in_off = in_id - ID_BASE;
    assign in_hit = (in_id >= ID_BASE) && (in_off < 11'(MOTOR_COUNT));

    assign s_tready = (state_reg == ST_IDLE);
    assign pready   = 1'b1;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_DECIMATION: prdata = {24'd0, decim_reg};
            REG_PROCESS:    prdata = {16'd0, pnoise_reg};
            REG_MEASURE:    prdata = {16'd0, mnoise_reg};
            default:        prdata = '0;
        endcase
    end

    logic [16:0] k_sat;
    assign k_sat = drsp.quot[16] ? 17'd65535 : drsp.quot;

    logic signed [43:0] est_sum;
    logic signed [31:0] est_sat;
    logic signed [59:0] prod_floor;
    assign prod_floor = prod_reg >>> 16;
    assign est_sum = 44'(est_reg[slot_reg]) + 44'(prod_floor);
    assign est_sat = (est_sum > 44'sd2147483647) ? 32'sh7fffffff :
                     (est_sum < -44'sd2147483648) ? 32'sh80000000 : est_sum[31:0];

    logic [50:0] var_prod;
    logic [34:0] var_q;
    assign var_prod = (51'd65536 - 51'(k_reg)) * 51'(vp_reg);
    assign var_q = var_prod[50:16];

    logic signed [31:0] est_q;
    logic signed [23:0] est_div;
    logic signed [15:0] est_out;
    assign est_q = est_reg[slot_reg];
    assign est_div = 24'((est_q + ((est_q < 0) ? 32'sd255 : 32'sd0)) >>> 8);
    assign est_out = (est_div > 24'sd32767) ? 16'sh7fff :
                     (est_div < -24'sd32768) ? 16'sh8000 : est_div[15:0];

    logic signed [17:0] d_unw, d_jmp, jump;
    logic signed [15:0] fs_db, d_sat;
    logic               jmp_hi, jmp_lo;
    assign fs_db = (fs_reg < 16'(SpeedDeadband) && fs_reg > -16'(SpeedDeadband)) ? 16'sd0
                   : fs_reg;
    always_comb begin
        d_unw = d_reg;
        if (fs_db >= 0 && d_reg < -18'(UnwrapMargin))
            d_unw = d_reg + 18'(ENCODER_COUNTS);
        else if (fs_db < 0 && d_reg > 18'(UnwrapMargin))
            d_unw = d_reg - 18'(ENCODER_COUNTS);
    end
    assign jump   = d_reg - 18'(good_reg[m_reg]);
    assign jmp_hi = jump > 18'(JumpLimit);
    assign jmp_lo = jump < -18'(JumpLimit);
    assign d_jmp  = jmp_hi ? d_reg - 18'(ENCODER_COUNTS) :
                    jmp_lo ? d_reg + 18'(ENCODER_COUNTS) : d_reg;
    assign d_sat  = (d_jmp > 18'sd32767) ? 16'sh7fff :
                    (d_jmp < -18'sd32768) ? 16'sh8000 : d_jmp[15:0];

    always_comb begin
        state_next = state_reg;
        dreq.start = 1'b0;
        dreq.vp    = vp_reg;
        dreq.den   = 35'(vp_reg) + {11'd0, mnoise_reg, 8'd0};
        case (state_reg)
            ST_IDLE:  if (s_tvalid && in_hit) state_next = ST_PRED;
            ST_PRED:  state_next = ST_DIV;
            ST_DIV:   begin
                dreq.start = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:   if (drsp.done) state_next = ST_EST;
            ST_EST:   state_next = ST_VAR;
            ST_VAR:   state_next = ST_POST;
            ST_POST:  state_next = (!phase_reg && upd_reg) ? ST_UNWRP : ST_OUT;
            ST_UNWRP: state_next = ST_JUMP;
            ST_JUMP:  state_next = ST_PRED;
            ST_OUT:   if (!out_valid_reg) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            decim_reg     <= 8'd1;
            pnoise_reg    <= 16'd600;
            mnoise_reg    <= 16'd5000;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                cnt_reg[i]  <= '0;
                prev_reg[i] <= '0;
                good_reg[i] <= '0;
            end
            for (int i = 0; i < 2 * MOTOR_COUNT; i++) begin
                est_reg[i] <= '0;
                var_reg[i] <= VARIANCE_RESET;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_DECIMATION: decim_reg  <= pwdata[7:0];
                    REG_PROCESS:    pnoise_reg <= pwdata[15:0];
                    REG_MEASURE:    mnoise_reg <= pwdata[15:0];
                    default:        ;
                endcase
            end
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_tvalid && in_hit) begin
                    m_reg     <= MW'(in_off);
                    angle_reg <= s_tdata[23:11];
                    x_reg     <= 17'(signed'(s_tdata[39:24]));
                    slot_reg  <= SW'(in_off) + SW'(MOTOR_COUNT);
                    phase_reg <= 1'b0;
                    fd_reg    <= '0;
                    upd_reg   <= (8'(cnt_reg[MW'(in_off)] + 8'd1) == decim_reg);
                    cnt_reg[MW'(in_off)] <=
                        (8'(cnt_reg[MW'(in_off)] + 8'd1) == decim_reg) ? 8'd0
                        : 8'(cnt_reg[MW'(in_off)] + 8'd1);
                end
                ST_PRED: vp_reg <= 34'(var_reg[slot_reg]) + {10'd0, pnoise_reg, 8'd0};
                ST_DIV:  diff_reg <= 42'(x_reg) * 42'sd256 - 42'(est_reg[slot_reg]);
                ST_MUL:  if (drsp.done) begin
                    k_reg    <= k_sat;
                    prod_reg <= 60'(signed'({1'b0, k_sat})) * 60'(diff_reg);
                end
                ST_EST: est_reg[slot_reg] <= est_sat;
                ST_VAR: var_reg[slot_reg] <= (var_q > 35'hffffffff) ? 32'hffffffff
                                             : var_q[31:0];
                ST_POST: begin
                    if (!phase_reg) begin
                        fs_reg <= est_out;
                        d_reg  <= 18'(angle_reg) - 18'(prev_reg[m_reg]);
                        if (upd_reg) prev_reg[m_reg] <= angle_reg;
                    end else begin
                        fd_reg <= est_out;
                    end
                end
                ST_UNWRP: begin
                    fs_reg <= fs_db;
                    d_reg  <= d_unw;
                end
                ST_JUMP: begin
                    if (!jmp_hi && !jmp_lo) good_reg[m_reg] <= d_sat;
                    x_reg     <= 17'(d_sat);
                    slot_reg  <= SW'(m_reg);
                    phase_reg <= 1'b1;
                end
                ST_OUT: if (!out_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    out_m_reg     <= 2'(m_reg);
                    out_fs_reg    <= fs_reg;
                    out_fd_reg    <= fd_reg;
                    out_upd_reg   <= upd_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_fd_reg, out_fs_reg, out_m_reg};
    assign m_tuser  = out_upd_reg;

endmodule

@@ hw/rtl/mfuf_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain divider
// Restoring divider, one quotient bit per cycle, for vp*65536 / den.
// ----------------------------------------------------------------------------
module mfuf_divider
    import mfuf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [35:0] rem_reg, rem_next;
    logic [16:0] quot_reg, quot_next;
    logic [34:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] shifted;

    assign shifted = {rem_reg[34:0], 1'b0};

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            // With vp < den, vp is already the remainder of the upper part.
            rem_next  = {2'b0, req.vp};
            den_next  = req.den;
            quot_next = '0;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next  = shifted - {1'b0, den_reg};
                quot_next = {quot_reg[15:0], 1'b1};
            end else begin
                rem_next  = shifted;
                quot_next = {quot_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback unwrap and filter regression
// Drives CAN frames through the stream input, predicts every filtered result
// in a scoreboard and compares it field by field, across several settings.
// ----------------------------------------------------------------------------

class motor_feedback_scoreboard;
    bit [7:0]         decimation;
    bit [15:0]        proc_noise;
    bit [15:0]        meas_noise;
    bit [7:0]         frame_cnt [4];
    bit [12:0]        prev_angle [4];
    bit signed [15:0] good_delta [4];
    bit signed [31:0] est [8];
    bit [31:0]        var_q8 [8];
    bit [1:0]         exp_motor [$];
    bit signed [15:0] exp_speed [$];
    bit               exp_upd [$];
    bit signed [15:0] exp_delta [$];
    int               errors;
    int               checked;
    int               updates;

    function new();
        decimation = 1;
        proc_noise = 600;
        meas_noise = 5000;
        for (int i = 0; i < 4; i++) begin
            frame_cnt[i] = 0;
            prev_angle[i] = 0;
            good_delta[i] = 0;
        end
        for (int i = 0; i < 8; i++) begin
            est[i] = 0;
            var_q8[i] = 32'd25600;
        end
        errors = 0;
        checked = 0;
        updates = 0;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint kalman_step(int slot, longint x);
        longint vp;
        longint den;
        longint k;
        longint e;
        longint prod;
        longint nv;
        longint q;
        vp = longint'(var_q8[slot]) + (longint'(proc_noise) << 8);
        den = vp + (longint'(meas_noise) << 8);
        k = den != 0 ? (vp << 16) / den : 0;
        if (k > 65535) k = 65535;
        e = est[slot];
        prod = k * (x * 256 - e);
        if (prod >= 0) q = prod >>> 16;
        else q = -(((-prod) + 65535) >>> 16);
        e = sat(e + q, -64'sd2147483648, 64'sd2147483647);
        est[slot] = 32'(e);
        nv = ((65536 - k) * vp) >>> 16;
        if (nv > 64'hFFFFFFFF) nv = 64'hFFFFFFFF;
        var_q8[slot] = 32'(nv);
        return sat(e / 256, -32768, 32767);
    endfunction

    function void note_frame(bit [10:0] id, bit [12:0] angle, bit signed [15:0] speed);
        int m;
        longint fs;
        longint fd;
        longint d;
        longint jump;
        bit upd;
        if (id < 11'h201 || id > 11'h204) return;
        m = int'(id - 11'h201);
        fd = 0;
        upd = 0;
        fs = kalman_step(m + 4, speed);
        frame_cnt[m] = frame_cnt[m] + 8'd1;
        if (frame_cnt[m] == decimation) begin
            frame_cnt[m] = 0;
            d = longint'(angle) - longint'(prev_angle[m]);
            prev_angle[m] = angle;
            if (fs < 5 && fs > -5) fs = 0;
            if (fs >= 0 && d < -10) d += 8192;
            else if (fs < 0 && d > 10) d -= 8192;
            jump = d - longint'(good_delta[m]);
            if (jump > 4000) begin
                d = sat(d - 8192, -32768, 32767);
            end else if (jump < -4000) begin
                d = sat(d + 8192, -32768, 32767);
            end else begin
                d = sat(d, -32768, 32767);
                good_delta[m] = 16'(d);
            end
            fd = kalman_step(m, d);
            upd = 1;
        end
        exp_motor.push_back(2'(m));
        exp_speed.push_back(16'(fs));
        exp_upd.push_back(upd);
        exp_delta.push_back(16'(fd));
    endfunction

    function void check_result(bit [1:0] m, bit signed [15:0] s, bit u, bit signed [15:0] d);
        checked++;
        if (exp_motor.size() == 0) begin
            $error("result with nothing expected: motor %0d", m);
            errors++;
            return;
        end
        if (u) updates++;
        if (exp_motor[0] != m) begin
            $error("motor_index: expected %0d, got %0d", exp_motor[0], m);
            errors++;
        end
        if (exp_speed[0] != s) begin
            $error("speed_filtered: expected %0d, got %0d", exp_speed[0], s);
            errors++;
        end
        if (exp_upd[0] != u) begin
            $error("angle_updated: expected %0d, got %0d", exp_upd[0], u);
            errors++;
        end
        if (exp_delta[0] != d) begin
            $error("delta_filtered: expected %0d, got %0d", exp_delta[0], d);
            errors++;
        end
        void'(exp_motor.pop_front());
        void'(exp_speed.pop_front());
        void'(exp_upd.pop_front());
        void'(exp_delta.pop_front());
    endfunction

    function int pending();
        return exp_motor.size();
    endfunction
endclass

module tb
    import mfuf_pkg::*;
();

    localparam int IdleLimit = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    motor_feedback_scoreboard frame_board;
    int  frames_sent;
    int  idle_cycles;
    bit  hold_off;

    motor_feedback_unwrap_filter_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            frame_board.check_result(m_tdata[1:0], m_tdata[17:2], m_tuser, m_tdata[33:18]);
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("receiver or sender stuck");
            $display("motor_feedback_unwrap_filter_unit regression: fail");
            $finish;
        end
    end

    // Receiver stall pattern; a long hold-off can be requested on top of it.
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (hold_off) m_tready <= 0;
            else case ($urandom_range(0, 3))
                0: m_tready <= 0;
                default: m_tready <= 1;
            endcase
        end
    end

    task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (index)
            REG_DECIMATION: frame_board.decimation = value[7:0];
            REG_PROCESS:    frame_board.proc_noise = value[15:0];
            default:        frame_board.meas_noise = value[15:0];
        endcase
        @(negedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_frame(input logic [10:0] id, input logic [12:0] angle,
                              input logic [15:0] speed);
        s_tvalid <= 1;
        s_tdata <= {speed, angle, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_board.note_frame(id, angle, speed);
        frames_sent++;
        @(negedge aclk);
    endtask

    task automatic send_burst_gap();
        if ($urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    endtask

    task automatic drain();
        while (frame_board.pending() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic random_frames(input int count);
        logic [12:0] ang [4];
        logic [10:0] id;
        int m;
        logic signed [15:0] spd;
        spd = '0;
        for (int i = 0; i < 4; i++) ang[i] = 13'($urandom_range(0, 8191));
        for (int n = 0; n < count; n++) begin
            m = int'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: id = 11'($urandom_range(0, 2047));
                1: begin
                    id = 11'($urandom_range(0, 2047));
                    ang[m] = 13'($urandom_range(0, 8191));
                    spd = 16'($urandom);
                end
                default: begin
                    id = 11'(11'h201 + m);
                    spd = 16'(int'($urandom_range(0, 6000)) - 3000);
                    ang[m] = ang[m] + spd[15:3];
                end
            endcase
            if ($urandom_range(0, 15) == 0) spd = 16'($urandom);
            send_frame(id, ang[m], spd);
            send_burst_gap();
        end
        s_tvalid <= 0;
    endtask

    initial begin
        frame_board = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        hold_off = 0;
        frames_sent = 0;
        idle_cycles = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // Directed frames: field extremes, wrap in both directions, jumps, others.
        send_frame(11'h201, 13'd0, 16'sd0);
        send_frame(11'h202, 13'd8191, 16'sd32767);
        send_frame(11'h203, 13'd8191, 16'h8000);
        send_frame(11'h204, 13'd4000, 16'sd3);
        send_frame(11'h201, 13'd8100, 16'sd1000);
        send_frame(11'h201, 13'd50, 16'sd1000);
        send_frame(11'h202, 13'd30, -16'sd2000);
        send_frame(11'h202, 13'd8150, -16'sd2000);
        send_frame(11'h203, 13'd4500, 16'sd0);
        send_frame(11'h203, 13'd200, 16'sd0);
        send_frame(11'h204, 13'd4005, -16'sd4);
        send_frame(11'h200, 13'd8191, 16'hFFFF);
        send_frame(11'h205, 13'd1, 16'sd1);
        send_frame(11'h7FF, 13'd8191, 16'hFFFF);
        send_frame(11'h000, 13'd0, 16'sd0);
        s_tvalid <= 0;
        drain();

        // Long receiver hold-off while frames keep coming.
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            random_frames(20);
        join
        drain();

        reg_write(REG_DECIMATION, 32'd255);
        reg_write(REG_PROCESS, 32'd0);
        reg_write(REG_MEASURE, 32'd1);
        random_frames(150);
        drain();
        reg_write(REG_DECIMATION, 32'd0);
        reg_write(REG_PROCESS, 32'd65535);
        reg_write(REG_MEASURE, 32'd65535);
        random_frames(150);
        drain();
        reg_write(REG_DECIMATION, 32'd3);
        reg_write(REG_PROCESS, 32'd1200);
        reg_write(REG_MEASURE, 32'd300);
        random_frames(400);
        drain();
        reg_write(REG_DECIMATION, 32'd1);
        reg_write(REG_PROCESS, 32'd600);
        reg_write(REG_MEASURE, 32'd5000);
        random_frames(620);
        drain();

        $display("Sent %0d frames over five register settings.", frames_sent);
        $display("%0d results checked, %0d with angle updates.",
                 frame_board.checked, frame_board.updates);
        if (frame_board.errors == 0 && frame_board.pending() == 0)
            $display("motor_feedback_unwrap_filter_unit regression: pass");
        else
            $display("motor_feedback_unwrap_filter_unit regression: fail");
        $finish;
    end
endmodule
